// ----- rtl/double_hash_string_set_unit_assert.svh -----
// Assertion macros used by dhss_back.
`ifndef DOUBLE_HASH_STRING_SET_UNIT_ASSERT_SVH
`define DOUBLE_HASH_STRING_SET_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DHSS_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DHSS_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dhss_pkg.sv -----
`timescale 1ns / 1ps
package dhss_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_FIND   = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic [1:0] ST_NEVER   = 2'd0;
    localparam logic [1:0] ST_USED    = 2'd1;
    localparam logic [1:0] ST_DELETED = 2'd2;

    typedef struct packed {
        logic       en;
        logic       bank;
        logic [7:0] idx;
        logic [7:0] data;
    } t_kb_wr;

endpackage

// ----- rtl/double_hash_string_set_unit.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Contents
// s         in         tdata: key_byte[7:0]; tuser: req_type[1:0]; tlast: key_last
// m         out        tdata: success[0], zeros above
// cfg       in         write enable and table_size[8:0]
//
// Each key byte is reduced in the front hash reducer before the next byte is taken. A
// request probes slots, compares bytes and copies bytes one after another, all on the
// single port of the slot memories.
// After reset every entry of the slot state memory is cleared before any byte
// is taken. The queue holds the request in progress and one more; the front stalls its
// input while the queue is full.
module double_hash_string_set_unit #(
    parameter int TABLE_DEPTH   = 256,
    parameter int MAX_KEY_BYTES = 100
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // key_byte[7:0]
    input  logic [1:0] i_s_tuser,   // req_type[1:0]
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // success[0], zero padding [7:1]
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_wdata
);

    localparam int HW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = $clog2(MAX_KEY_BYTES + 1);
    localparam int EW = 2 * HW + LW + 4;

    logic              w_push;
    logic              w_pop;
    logic              w_full;
    logic              w_empty;
    logic [EW-1:0]     w_qin;
    logic [EW-1:0]     w_qout;
    logic              w_clr_done;
    logic [NW-1:0]     w_size;
    logic              w_success;
    dhss_pkg::t_kb_wr  w_kb_wr;

    dhss_front #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_byte     (i_s_tdata),
        .i_kind     (i_s_tuser),
        .i_last     (i_s_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_clr_done (w_clr_done),
        .i_q_full   (w_full),
        .o_q_push   (w_push),
        .o_q_data   (w_qin),
        .o_kb_wr    (w_kb_wr),
        .o_size     (w_size)
    );

    dhss_fifo #(
        .W(EW)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_qin),
        .i_pop  (w_pop),
        .o_data (w_qout),
        .o_full (w_full),
        .o_empty(w_empty)
    );

    dhss_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_empty),
        .i_q_data   (w_qout),
        .o_q_pop    (w_pop),
        .i_kb_wr    (w_kb_wr),
        .i_size     (w_size),
        .o_clr_done (w_clr_done),
        .o_m_valid  (o_m_tvalid),
        .i_m_ready  (i_m_tready),
        .o_m_success(w_success)
    );

    assign o_m_tdata = {7'd0, w_success};

endmodule

// ----- rtl/dhss_fifo.sv -----
`timescale 1ns / 1ps
module dhss_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/dhss_front.sv -----
`timescale 1ns / 1ps
module dhss_front #(
    parameter int TABLE_DEPTH   = 256,
    parameter int MAX_KEY_BYTES = 100
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_byte,
    input  logic [1:0]            i_kind,
    input  logic                  i_last,
    input  logic                  i_cfg_we,
    input  logic [8:0]            i_cfg_wdata,
    input  logic                  i_clr_done,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output logic [2*$clog2(TABLE_DEPTH)+$clog2(MAX_KEY_BYTES+1)+3:0] o_q_data,
    output dhss_pkg::t_kb_wr      o_kb_wr,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] o_size
);

    localparam int HW  = $clog2(TABLE_DEPTH);
    localparam int NW  = $clog2(TABLE_DEPTH + 1);
    localparam int LW  = $clog2(MAX_KEY_BYTES + 1);
    localparam int VW  = ((HW > 8) ? HW : 8) + 2;
    localparam int RW  = NW + VW;
    localparam int KW  = $clog2(VW);
    localparam int CW  = (NW > 9) ? NW : 9;
    localparam int RED = 4;

    typedef struct packed {
        logic [1:0]    kind;
        logic [HW-1:0] h1;
        logic [HW-1:0] h2;
        logic [LW-1:0] len;
        logic          ovf;
        logic          bank;
    } t_entry;

    logic [8:0]    r_size;
    logic [CW-1:0] w_size_ext;
    logic          r_busy;
    logic [KW-1:0] r_k;
    logic [VW-1:0] r_v1;
    logic [VW-1:0] r_v2;
    logic [HW-1:0] r_h1;
    logic [HW-1:0] r_h2;
    logic [LW-1:0] r_len;
    logic          r_ovf;
    logic          r_bank;
    logic          r_last;
    logic [1:0]    r_kind;
    logic [RW-1:0] w_a1;
    logic [RW-1:0] w_a2;
    logic [RW-1:0] w_d;
    logic          w_acc;
    logic          w_done;
    t_entry        w_entry;

    // Table size clamped to the range one to the table depth.
    always_comb begin
        w_size_ext = CW'(r_size);
        if (w_size_ext == '0) begin
            o_size = NW'(1);
        end else if (w_size_ext > CW'(TABLE_DEPTH)) begin
            o_size = NW'(TABLE_DEPTH);
        end else begin
            o_size = w_size_ext[NW-1:0];
        end
    end

    assign o_ready = i_clr_done && !r_busy && !i_q_full;
    assign w_acc   = i_valid && o_ready;
    assign w_done  = r_busy && (r_k < KW'(RED));

    // Restoring remainder for both hashes, RED bit positions at a time.
    always_comb begin
        w_a1 = RW'(r_v1);
        w_a2 = RW'(r_v2);
        w_d  = '0;
        for (int j = 0; j < RED; j++) begin
            if (int'(r_k) - j >= 0) begin
                w_d = RW'(o_size) << (int'(r_k) - j);
                if (w_a1 >= w_d) begin
                    w_a1 = w_a1 - w_d;
                end
                if (w_a2 >= w_d) begin
                    w_a2 = w_a2 - w_d;
                end
            end
        end
    end

    always_comb begin
        w_entry.kind = r_kind;
        w_entry.h1   = w_a1[HW-1:0];
        w_entry.h2   = w_a2[HW-1:0];
        w_entry.len  = r_len;
        w_entry.ovf  = r_ovf;
        w_entry.bank = r_bank;
    end

    assign o_q_push = w_done && r_last;
    assign o_q_data = w_entry;

    always_comb begin
        o_kb_wr.en   = w_acc && (r_len < LW'(MAX_KEY_BYTES));
        o_kb_wr.bank = r_bank;
        o_kb_wr.idx  = 8'(r_len);
        o_kb_wr.data = i_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 9'd256;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_h1   <= '0;
            r_h2   <= '0;
            r_len  <= '0;
            r_ovf  <= 1'b0;
            r_bank <= 1'b0;
            r_last <= 1'b0;
        end else if (w_acc) begin
            r_v1   <= VW'(r_h1) + VW'(i_byte);
            r_v2   <= (VW'(r_h2) << 1) + VW'(r_h2) + VW'(i_byte);
            r_k    <= KW'(VW - 1);
            r_busy <= 1'b1;
            r_last <= i_last;
            r_kind <= i_kind;
            if (r_len < LW'(MAX_KEY_BYTES)) begin
                r_len <= r_len + LW'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end else if (r_busy) begin
            r_v1 <= w_a1[VW-1:0];
            r_v2 <= w_a2[VW-1:0];
            if (w_done) begin
                r_busy <= 1'b0;
                if (r_last) begin
                    r_h1   <= '0;
                    r_h2   <= '0;
                    r_len  <= '0;
                    r_ovf  <= 1'b0;
                    r_bank <= ~r_bank;
                end else begin
                    r_h1 <= w_a1[HW-1:0];
                    r_h2 <= w_a2[HW-1:0];
                end
            end else begin
                r_k <= r_k - KW'(RED);
            end
        end
    end

endmodule

// ----- rtl/dhss_back.sv -----
`timescale 1ns / 1ps
`include "double_hash_string_set_unit_assert.svh"
module dhss_back #(
    parameter int TABLE_DEPTH   = 256,
    parameter int MAX_KEY_BYTES = 100
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  logic [2*$clog2(TABLE_DEPTH)+$clog2(MAX_KEY_BYTES+1)+3:0] i_q_data,
    output logic                  o_q_pop,
    input  dhss_pkg::t_kb_wr      i_kb_wr,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] i_size,
    output logic                  o_clr_done,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    output logic                  o_m_success
);

    localparam int HW  = $clog2(TABLE_DEPTH);
    localparam int NW  = $clog2(TABLE_DEPTH + 1);
    localparam int LW  = $clog2(MAX_KEY_BYTES + 1);
    localparam int KBW = $clog2(2 * MAX_KEY_BYTES);
    localparam int SBW = $clog2(TABLE_DEPTH * MAX_KEY_BYTES);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_PRB  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_CRD  = 4'd4;
    localparam logic [3:0] S_CCK  = 4'd5;
    localparam logic [3:0] S_PRD  = 4'd6;
    localparam logic [3:0] S_PWR  = 4'd7;
    localparam logic [3:0] S_RSP  = 4'd8;

    typedef struct packed {
        logic [1:0]    kind;
        logic [HW-1:0] h1;
        logic [HW-1:0] h2;
        logic [LW-1:0] len;
        logic          ovf;
        logic          bank;
    } t_entry;

    logic [7:0]    m_kbuf [2*MAX_KEY_BYTES];
    logic [7:0]    m_sb   [TABLE_DEPTH*MAX_KEY_BYTES];
    logic [1:0]    m_st   [TABLE_DEPTH];
    logic [LW-1:0] m_len  [TABLE_DEPTH];

    logic [3:0]    r_state;
    logic [HW-1:0] r_x;
    logic [HW-1:0] r_y;
    logic [NW-1:0] r_cnt;
    logic [LW-1:0] r_i;
    logic [LW-1:0] r_len;
    logic [1:0]    r_kind;
    logic          r_bank;
    logic          r_res;
    logic          r_ov;
    logic [7:0]    r_kb_rd;
    logic [7:0]    r_sb_rd;
    logic [1:0]    r_st_rd;
    logic [LW-1:0] r_len_rd;

    t_entry        w_entry;
    logic [KBW-1:0] w_kb_wa;
    logic [KBW-1:0] w_kb_ra;
    logic [SBW-1:0] w_sb_a;
    logic [HW:0]   w_sum;
    logic [HW:0]   w_wrap;
    logic [HW-1:0] w_x_next;
    logic          w_last_probe;
    logic          w_ins;
    logic          w_free;
    logic          w_cmp;
    logic          w_fail;
    logic          w_byte_eq;
    logic          w_last_byte;
    logic          w_st_we;
    logic [1:0]    w_st_wd;

    assign w_entry = i_q_data;
    assign w_kb_wa = i_kb_wr.bank ? KBW'(MAX_KEY_BYTES) + KBW'(i_kb_wr.idx) : KBW'(i_kb_wr.idx);
    assign w_kb_ra = r_bank ? KBW'(MAX_KEY_BYTES) + KBW'(r_i) : KBW'(r_i);
    assign w_sb_a  = SBW'(r_x) * SBW'(MAX_KEY_BYTES) + SBW'(r_i);

    assign w_sum        = (HW+1)'(r_x) + (HW+1)'(r_y);
    assign w_wrap       = (w_sum >= (HW+1)'(i_size)) ? w_sum - (HW+1)'(i_size) : w_sum;
    assign w_x_next     = w_wrap[HW-1:0];
    assign w_last_probe = ((r_cnt + NW'(1)) == i_size);

    assign w_ins  = (r_kind == dhss_pkg::REQ_INSERT);
    assign w_free = w_ins && ((r_st_rd == dhss_pkg::ST_NEVER) || (r_st_rd == dhss_pkg::ST_DELETED));
    assign w_cmp  = w_ins ? (!w_free && (r_len_rd == r_len))
                          : ((r_st_rd == dhss_pkg::ST_USED) && (r_len_rd == r_len));
    assign w_fail = !w_ins && (r_st_rd == dhss_pkg::ST_NEVER);

    assign w_byte_eq   = (r_kb_rd == r_sb_rd);
    assign w_last_byte = ((r_i + LW'(1)) == r_len);

    always_comb begin
        w_st_we = 1'b0;
        w_st_wd = dhss_pkg::ST_NEVER;
        if (r_state == S_CLR) begin
            w_st_we = 1'b1;
        end else if (r_state == S_PWR && w_last_byte) begin
            w_st_we = 1'b1;
            w_st_wd = dhss_pkg::ST_USED;
        end else if (r_state == S_CCK && w_byte_eq && w_last_byte &&
                     r_kind == dhss_pkg::REQ_REMOVE) begin
            w_st_we = 1'b1;
            w_st_wd = dhss_pkg::ST_DELETED;
        end
    end

    assign o_q_pop     = (r_state == S_RSP) && (!r_ov || i_m_ready);
    assign o_clr_done  = (r_state != S_CLR);
    assign o_m_valid   = r_ov;

    always_ff @(posedge i_clk) begin
        if (i_kb_wr.en) begin
            m_kbuf[w_kb_wa] <= i_kb_wr.data;
        end
        r_kb_rd <= m_kbuf[w_kb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PWR) begin
            m_sb[w_sb_a] <= r_kb_rd;
        end
        r_sb_rd <= m_sb[w_sb_a];
    end

    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            m_st[r_x] <= w_st_wd;
        end
        r_st_rd <= m_st[r_x];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PWR && w_last_byte) begin
            m_len[r_x] <= r_len;
        end
        r_len_rd <= m_len[r_x];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_q_pop) begin
            r_ov        <= 1'b1;
            o_m_success <= r_res;
        end else if (i_m_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_x     <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    if (r_x == HW'(TABLE_DEPTH - 1)) begin
                        r_x     <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_x <= r_x + HW'(1);
                    end
                end
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_x    <= w_entry.h1;
                        r_y    <= w_entry.h2;
                        r_len  <= w_entry.len;
                        r_kind <= w_entry.kind;
                        r_bank <= w_entry.bank;
                        r_cnt  <= '0;
                        if (w_entry.ovf || w_entry.kind == dhss_pkg::REQ_NONE) begin
                            r_res   <= 1'b0;
                            r_state <= S_RSP;
                        end else begin
                            r_state <= S_PRB;
                        end
                    end
                end
                S_PRB: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (w_free) begin
                        r_i     <= '0;
                        r_state <= S_PRD;
                    end else if (w_cmp) begin
                        r_i     <= '0;
                        r_state <= S_CRD;
                    end else if (w_fail || w_last_probe) begin
                        r_res   <= 1'b0;
                        r_state <= S_RSP;
                    end else begin
                        r_x     <= w_x_next;
                        r_cnt   <= r_cnt + NW'(1);
                        r_state <= S_PRB;
                    end
                end
                S_CRD: begin
                    r_state <= S_CCK;
                end
                S_CCK: begin
                    if (!w_byte_eq) begin
                        if (w_last_probe) begin
                            r_res   <= 1'b0;
                            r_state <= S_RSP;
                        end else begin
                            r_x     <= w_x_next;
                            r_cnt   <= r_cnt + NW'(1);
                            r_state <= S_PRB;
                        end
                    end else if (w_last_byte) begin
                        r_res   <= !w_ins;
                        r_state <= S_RSP;
                    end else begin
                        r_i     <= r_i + LW'(1);
                        r_state <= S_CRD;
                    end
                end
                S_PRD: begin
                    r_state <= S_PWR;
                end
                S_PWR: begin
                    if (w_last_byte) begin
                        r_res   <= 1'b1;
                        r_state <= S_RSP;
                    end else begin
                        r_i     <= r_i + LW'(1);
                        r_state <= S_PRD;
                    end
                end
                S_RSP: begin
                    if (o_q_pop) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `DHSS_AST_IMP(a_pop_with_entry, o_q_pop, (r_state == S_RSP) && !i_q_empty, "pop without a queued request")
    `DHSS_AST_IMP(a_no_key_in_clear, r_state == S_CLR, !i_kb_wr.en, "key byte taken during clearing")
    `DHSS_AST_IMP(a_no_result_in_clear, r_state == S_CLR, !o_m_valid, "result shown during clearing")
    `DHSS_AST_NXT(a_pop_gives_result, o_q_pop, o_m_valid, "popped request gave no result")

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;

    localparam int DEPTH    = 256;
    localparam int KEY_MAX  = 100;
    localparam int IDLE_PCT = 34;
    localparam int STALL_LIMIT = 400000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] key_byte;
        logic       last;
    } t_byte_req;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       cfg_we = 1'b0;
    logic [8:0] cfg_wdata = '0;

    double_hash_string_set_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Set model: table contents, running key and hashes.
    logic [7:0] slot_key [DEPTH][KEY_MAX];
    int         slot_len [DEPTH];
    logic [1:0] slot_state [DEPTH];
    logic [7:0] key_buf [KEY_MAX];
    int         key_len;
    bit         key_too_long;
    int         hash_home;
    int         hash_stride;
    int         size_reg;

    t_byte_req  pending_bytes [$];
    bit         answers_due [$];
    int         errors;
    bit         calm;
    bit         hold_wanted;

    function automatic int slots_live();
        if (size_reg == 0) return 1;
        if (size_reg > DEPTH) return DEPTH;
        return size_reg;
    endfunction

    function automatic bit key_matches(int s);
        if (slot_len[s] != key_len) return 1'b0;
        for (int j = 0; j < key_len; j++)
            if (slot_key[s][j] != key_buf[j]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit lookup_and_update(logic [1:0] kind);
        int n;
        int x;
        int y;
        n = slots_live();
        x = hash_home % n;
        y = hash_stride % n;
        if (key_too_long || kind == dhss_pkg::REQ_NONE) return 1'b0;
        for (int i = 0; i < n; i++) begin
            if (kind == dhss_pkg::REQ_INSERT) begin
                if (slot_state[x] != dhss_pkg::ST_USED) begin
                    for (int j = 0; j < key_len; j++) slot_key[x][j] = key_buf[j];
                    slot_len[x] = key_len;
                    slot_state[x] = dhss_pkg::ST_USED;
                    return 1'b1;
                end
                if (key_matches(x)) return 1'b0;
            end else begin
                if (slot_state[x] == dhss_pkg::ST_USED && key_matches(x)) begin
                    if (kind == dhss_pkg::REQ_REMOVE) slot_state[x] = dhss_pkg::ST_DELETED;
                    return 1'b1;
                end
                if (slot_state[x] == dhss_pkg::ST_NEVER) return 1'b0;
            end
            x = (x + y) % n;
        end
        return 1'b0;
    endfunction

    function automatic void absorb_byte(t_byte_req r);
        int n;
        n = slots_live();
        hash_home = (hash_home + r.key_byte) % n;
        hash_stride = (3 * hash_stride + r.key_byte) % n;
        if (key_len < KEY_MAX) begin
            key_buf[key_len] = r.key_byte;
            key_len++;
        end else begin
            key_too_long = 1'b1;
        end
        if (r.last) begin
            answers_due.push_back(lookup_and_update(r.kind));
            key_len = 0;
            key_too_long = 1'b0;
            hash_home = 0;
            hash_stride = 0;
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Driver.
    always @(posedge i_clk) begin
        t_byte_req r;
        if (i_rst_n) begin
            if (s_tvalid && s_tready)
                absorb_byte('{kind: s_tuser, key_byte: s_tdata, last: s_tlast});
            if (!(s_tvalid && !s_tready)) begin
                if (pending_bytes.size() > 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    r = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= r.key_byte;
                    s_tuser  <= r.kind;
                    s_tlast  <= r.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor, with its own long hold-off when asked.
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("unexpected result, success", m_tdata[0], -1);
                end else begin
                    want = answers_due.pop_front();
                    if (m_tdata[0] !== want) report_mismatch("success", m_tdata[0], want);
                    if (m_tdata[7:1] !== 7'd0) report_mismatch("padding", m_tdata[7:1], 0);
                end
            end
            if (hold_wanted && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= 600;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus.
    logic [7:0] pool_key [16][KEY_MAX + 6];
    int         pool_len [16];

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(99) < 3) return 8'd0;
        return 8'($urandom_range(255, 1));
    endfunction

    function automatic void queue_key(int p, logic [1:0] kind);
        t_byte_req r;
        for (int j = 0; j < pool_len[p]; j++) begin
            r.key_byte = pool_key[p][j];
            r.last = (j == pool_len[p] - 1);
            r.kind = r.last ? kind : 2'($urandom_range(3));
            pending_bytes.push_back(r);
        end
    endfunction

    function automatic void make_key(int p, int len);
        pool_len[p] = len;
        for (int j = 0; j < len; j++) pool_key[p][j] = rand_byte();
    endfunction

    task automatic wait_idle();
        while (pending_bytes.size() > 0 || s_tvalid || answers_due.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_size(int v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 9'(v);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        size_reg = v;
    endtask

    task automatic random_phase(int budget);
        int start;
        int p;
        int k;
        logic [1:0] kind;
        start = pending_bytes.size();
        for (int i = 0; i < 16; i++)
            make_key(i, ($urandom_range(99) < 6) ? $urandom_range(KEY_MAX + 5, 95)
                                                : $urandom_range(4, 1));
        while (pending_bytes.size() - start < budget) begin
            k = $urandom_range(99);
            kind = (k < 45) ? dhss_pkg::REQ_INSERT : (k < 75) ? dhss_pkg::REQ_FIND :
                   (k < 95) ? dhss_pkg::REQ_REMOVE : dhss_pkg::REQ_NONE;
            p = $urandom_range(15);
            if ($urandom_range(99) < 10) make_key(p, $urandom_range(8, 1));
            queue_key(p, kind);
        end
    endtask

    initial begin
        int sizes [8];
        sizes = '{256, 1, 0, 7, 511, 2, 13, 300};
        errors = 0;
        calm = 1'b0;
        hold_wanted = 1'b0;
        foreach (slot_state[i]) slot_state[i] = dhss_pkg::ST_NEVER;
        foreach (slot_len[i]) slot_len[i] = 0;
        key_len = 0;
        key_too_long = 1'b0;
        hash_home = 0;
        hash_stride = 0;
        size_reg = DEPTH;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: basic requests, duplicates, extreme bytes, bad kind, long keys.
        make_key(0, 1); pool_key[0][0] = 8'hFF;
        make_key(1, 2); pool_key[1][0] = 8'h00; pool_key[1][1] = 8'h01;
        queue_key(0, dhss_pkg::REQ_INSERT);
        queue_key(0, dhss_pkg::REQ_INSERT);
        queue_key(0, dhss_pkg::REQ_FIND);
        queue_key(1, dhss_pkg::REQ_FIND);
        queue_key(1, dhss_pkg::REQ_INSERT);
        queue_key(0, dhss_pkg::REQ_NONE);
        queue_key(0, dhss_pkg::REQ_REMOVE);
        queue_key(0, dhss_pkg::REQ_FIND);
        queue_key(0, dhss_pkg::REQ_REMOVE);
        queue_key(1, dhss_pkg::REQ_REMOVE);
        make_key(2, KEY_MAX);
        queue_key(2, dhss_pkg::REQ_INSERT);
        queue_key(2, dhss_pkg::REQ_FIND);
        make_key(3, KEY_MAX + 1);
        queue_key(3, dhss_pkg::REQ_INSERT);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            set_size(sizes[ph]);
            calm = (ph == 1);
            if (ph == 3) hold_wanted = 1'b1;
            random_phase(180);
            wait_idle();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0 && answers_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
